FILE: hw/rtl/sbb_pkg.sv
// Shared types and constants for the spectrum box blur.
package sbb_pkg;

	// Fixed field widths of the channels
	localparam int BIN_W    = 12;
	localparam int RADIUS_W = 3;

	// Quotient bits resolved per divider cycle
	localparam int DIV_BPC = 4;

	// Per-cycle control for the window cells
	typedef struct packed {
		logic shift;  // new bin enters, every cell passes its bin on
		logic clear;  // frame ended, drop all bins
	} sbb_cell_ctl_t;

endpackage

FILE: hw/rtl/sbb_if.sv
// Valid/ready channel interfaces for bins in, blurred bins out and the radius write.

interface sbb_in_if #(
	parameter int MAG_BITS = 24
);
	logic                valid;
	logic                ready;
	logic [MAG_BITS-1:0] mag_in;
	logic                frame_end;

	modport source (output valid, output mag_in, output frame_end, input ready);
	modport sink   (input valid, input mag_in, input frame_end, output ready);
endinterface

interface sbb_out_if #(
	parameter int MAG_BITS = 24
);
	import sbb_pkg::*;

	logic                valid;
	logic                ready;
	logic [MAG_BITS-1:0] mag_out;
	logic [BIN_W-1:0]    bin_number;
	logic                frame_done;
	logic                overlong;

	modport source (output valid, output mag_out, output bin_number, output frame_done,
		output overlong, input ready);
	modport sink   (input valid, input mag_out, input bin_number, input frame_done,
		input overlong, output ready);
endinterface

interface sbb_cfg_if;
	import sbb_pkg::*;

	logic                valid;
	logic                ready;
	logic [RADIUS_W-1:0] blur_radius;

	modport source (output valid, output blur_radius, input ready);
	modport sink   (input valid, input blur_radius, output ready);
endinterface

FILE: hw/rtl/sbb_cell.sv
// One window slot: holds a bin, shifts it to the neighbor, and adds into the running sum chain.
module sbb_cell #(
	parameter int MAG_BITS = 24,
	parameter int SUM_W    = 28,
	parameter int CNT_W    = 4,
	parameter int WIN_W    = 4,
	parameter int IDX      = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sbb_pkg::sbb_cell_ctl_t ctl,
	input  logic [MAG_BITS-1:0]   d_in,
	input  logic                  v_in,
	input  logic [WIN_W-1:0]      lo,
	input  logic [WIN_W-1:0]      hi,
	input  logic [SUM_W-1:0]      sum_in,
	input  logic [CNT_W-1:0]      cnt_in,
	output logic [MAG_BITS-1:0]   d_out,
	output logic                  v_out,
	output logic [SUM_W-1:0]      sum_out,
	output logic [CNT_W-1:0]      cnt_out
);
	import sbb_pkg::*;

	logic [MAG_BITS-1:0] data_q;
	logic                valid_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                sel;

	// Slot storage
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= d_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= v_in;
		end
	end

	// Slot counts if it holds a bin of this frame and lies in the window
	assign sel = valid_q && (WIN_W'(IDX) >= lo) && (WIN_W'(IDX) <= hi);

	// Partial sum and count move one cell per cycle
	always_ff @(posedge clk) begin
		sum_q <= sum_in + (sel ? SUM_W'(data_q) : '0);
		cnt_q <= cnt_in + CNT_W'(sel);
	end

	assign d_out   = data_q;
	assign v_out   = valid_q;
	assign sum_out = sum_q;
	assign cnt_out = cnt_q;

endmodule

FILE: hw/rtl/sbb_div.sv
// Multi-cycle unsigned divider, DIV_BPC quotient bits per cycle, for the window mean.
module sbb_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	import sbb_pkg::*;

	localparam int STEPS = (NUM_W + DIV_BPC - 1) / DIV_BPC;
	localparam int PAD_W = STEPS * DIV_BPC;
	localparam int STP_W = $clog2(STEPS + 1);

	logic [PAD_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [STP_W-1:0] step_q;
	logic             busy_q;
	logic             done_q;
	logic [PAD_W-1:0] num_nx;
	logic [DEN_W-1:0] rem_nx;

	// DIV_BPC restoring steps; quotient bits shift in at the bottom
	always_comb begin
		logic [DEN_W:0]   t;
		logic [DEN_W-1:0] r;
		logic [PAD_W-1:0] n;
		r = rem_q;
		n = num_q;
		for (int k = 0; k < DIV_BPC; k++) begin
			t = {r, n[PAD_W-1]};
			n = {n[PAD_W-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				t    = t - {1'b0, den_q};
				n[0] = 1'b1;
			end
			r = t[DEN_W-1:0];
		end
		num_nx = n;
		rem_nx = r;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= PAD_W'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
		end
	end

	// Step count and completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STP_W'(STEPS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = num_q[NUM_W-1:0];

endmodule

FILE: hw/rtl/spectrum_box_blur_top.sv
// Top level of the spectrum box blur: window cell chain, sequencer, divider, output register.
// A bin that passes unchanged goes from its slot straight to the output register; a blurred
//   bin first waits while its window sum runs down the cell chain, then goes through the
//   divider and then to the output register.
// One bin at a time: a new bin is taken only once every result that it releases has gone to the
//   output register; the last bin of a frame releases each pending slot in turn.
// Reset clears the window valid bits, counters and radius; no clearing pass is needed.
module spectrum_box_blur_top #(
	parameter int MAX_BINS   = 4096,
	parameter int MAX_RADIUS = 6,
	parameter int MAG_BITS   = 24
) (
	input logic    clk,
	input logic    arst_n,
	sbb_in_if.sink    bin_in,
	sbb_out_if.source bin_out,
	sbb_cfg_if.sink   cfg
);
	import sbb_pkg::*;

	localparam int WIN_LEN = 2 * MAX_RADIUS + 1;
	localparam int WIN_W   = $clog2(WIN_LEN);
	localparam int CNT_W   = $clog2(WIN_LEN + 1);
	localparam int SUM_W   = MAG_BITS + CNT_W;
	localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
	localparam int ARR_W   = $clog2(MAX_BINS + 1);
	localparam int BCNT_W  = $clog2(MAX_BINS);
	localparam int WAIT_W  = $clog2(WIN_LEN + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SLOT = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [RAD_W-1:0]    fr_q;
	logic [BCNT_W-1:0]   bin_q;
	logic [ARR_W-1:0]    arr_q;
	logic                long_q;
	logic                end_q;
	logic                last_q;
	logic [WIN_W-1:0]    slot_q;
	logic [WIN_W-1:0]    lo_q;
	logic [WIN_W-1:0]    hi_q;
	logic [WAIT_W-1:0]   wait_q;
	logic [MAG_BITS-1:0] res_q;

	logic                ov_q;
	logic [MAG_BITS-1:0] mag_out_q;
	logic [BIN_W-1:0]    bin_num_q;
	logic                done_q;
	logic                long_out_q;

	// Cell chain wiring; entry 0 feeds the first cell
	logic [MAG_BITS-1:0] d_ch [WIN_LEN+1];
	logic                v_ch [WIN_LEN+1];
	logic [SUM_W-1:0]    s_ch [WIN_LEN+1];
	logic [CNT_W-1:0]    c_ch [WIN_LEN+1];
	logic [WIN_LEN-1:0]  vld;
	logic [MAG_BITS-1:0] mag_s [WIN_LEN];
	sbb_cell_ctl_t       ctl;

	logic                acc;
	logic                fresh;
	logic [RAD_W-1:0]    fr_sat;
	logic [RAD_W-1:0]    fr_nx;
	logic [ARR_W-1:0]    arr_base;
	logic                long_base;
	logic [BCNT_W-1:0]   bin_base;
	logic                cur_v;
	logic                nxt_v;
	logic                is_last;
	logic                pass;
	logic                more;
	logic                out_free;
	logic                adv;
	logic                frame_clr;
	logic [WIN_W-1:0]    r_w;
	logic                div_start;
	logic                div_done;
	logic [SUM_W-1:0]    quot;

	assign cfg.ready    = 1'b1;
	assign bin_in.ready = (state_q == ST_IDLE);
	assign acc          = bin_in.valid && (state_q == ST_IDLE);

	// Radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg.valid) begin
			radius_q <= cfg.blur_radius;
		end
	end

	// Window cells
	assign d_ch[0] = bin_in.mag_in;
	assign v_ch[0] = 1'b1;
	assign s_ch[0] = '0;
	assign c_ch[0] = '0;

	assign ctl.shift = acc;
	assign ctl.clear = frame_clr;

	for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
		sbb_cell #(
			.MAG_BITS (MAG_BITS),
			.SUM_W    (SUM_W),
			.CNT_W    (CNT_W),
			.WIN_W    (WIN_W),
			.IDX      (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.d_in    (d_ch[i]),
			.v_in    (v_ch[i]),
			.lo      (lo_q),
			.hi      (hi_q),
			.sum_in  (s_ch[i]),
			.cnt_in  (c_ch[i]),
			.d_out   (d_ch[i+1]),
			.v_out   (v_ch[i+1]),
			.sum_out (s_ch[i+1]),
			.cnt_out (c_ch[i+1])
		);
		assign vld[i]   = v_ch[i+1];
		assign mag_s[i] = d_ch[i+1];
	end

	// Frame start: latch radius, restart counters
	assign fresh     = ~|vld;
	assign fr_sat    = (32'(radius_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_q);
	assign fr_nx     = fresh ? fr_sat : fr_q;
	assign arr_base  = fresh ? '0 : arr_q;
	assign long_base = fresh ? 1'b0 : long_q;
	assign bin_base  = fresh ? '0 : bin_q;

	// Current slot decode
	assign r_w      = WIN_W'(fr_q);
	assign cur_v    = vld[slot_q];
	assign nxt_v    = vld[slot_q + 1'b1];
	assign is_last  = end_q && (slot_q == '0);
	assign pass     = !nxt_v || is_last || (fr_q == '0);
	assign more     = end_q && (slot_q != '0);
	assign out_free = !ov_q || bin_out.ready;
	assign adv      = ((state_q == ST_SLOT) && !cur_v) || ((state_q == ST_OUT) && out_free);
	assign frame_clr = adv && !more && end_q;

	assign div_start = (state_q == ST_SUM) && (wait_q == '0);

	sbb_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (s_ch[WIN_LEN]),
		.den    (c_ch[WIN_LEN]),
		.done   (div_done),
		.quot   (quot)
	);

	// Sequencer: one result at a time, newest pending slot last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fr_q    <= '0;
			bin_q   <= '0;
			arr_q   <= '0;
			long_q  <= 1'b0;
			end_q   <= 1'b0;
			slot_q  <= '0;
			wait_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						fr_q  <= fr_nx;
						bin_q <= bin_base;
						if (32'(arr_base) >= MAX_BINS) begin
							long_q <= 1'b1;
							arr_q  <= arr_base;
						end else begin
							long_q <= long_base;
							arr_q  <= arr_base + 1'b1;
						end
						end_q   <= bin_in.frame_end;
						slot_q  <= WIN_W'(fr_nx);
						state_q <= ST_SLOT;
					end
				end
				ST_SLOT: begin
					if (cur_v) begin
						if (pass) begin
							state_q <= ST_OUT;
						end else begin
							wait_q  <= WAIT_W'(WIN_LEN);
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					if (wait_q == '0) begin
						state_q <= ST_DIV;
					end else begin
						wait_q <= wait_q - 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// counter restarts below when the frame closes
					if (out_free && !frame_clr && (32'(bin_q) < MAX_BINS - 1)) begin
						bin_q <= bin_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Move to the next pending slot or finish the transaction
			if (adv) begin
				if (more) begin
					slot_q  <= slot_q - 1'b1;
					state_q <= ST_SLOT;
				end else begin
					state_q <= ST_IDLE;
					if (end_q) begin
						bin_q  <= '0;
						arr_q  <= '0;
						long_q <= 1'b0;
					end
				end
			end
		end
	end

	// Window bounds and result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_SLOT) && cur_v) begin
			last_q <= is_last;
			res_q  <= mag_s[slot_q];
			lo_q   <= (slot_q >= r_w) ? (slot_q - r_w) : '0;
			hi_q   <= slot_q + r_w;
		end else if ((state_q == ST_DIV) && div_done) begin
			res_q <= MAG_BITS'(quot);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			ov_q <= 1'b1;
		end else if (bin_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			mag_out_q  <= res_q;
			bin_num_q  <= BIN_W'(bin_q);
			done_q     <= last_q;
			long_out_q <= long_q;
		end
	end

	assign bin_out.valid      = ov_q;
	assign bin_out.mag_out    = mag_out_q;
	assign bin_out.bin_number = bin_num_q;
	assign bin_out.frame_done = done_q;
	assign bin_out.overlong   = long_out_q;

endmodule

FILE: tb/tb_spectrum_box_blur_top.sv
// Self-checking testbench for the spectrum box blur: random frames, radius changes, back-pressure.
module tb_spectrum_box_blur_top;
	import sbb_pkg::*;

	localparam int MAG_W      = 24;
	localparam int MAX_BINS_P = 4096;
	localparam int MAX_RAD_P  = 6;
	localparam int WIN_SLOTS  = 2 * MAX_RAD_P + 1;
	localparam int SETTLE_CYC = 40;
	localparam int RAND_BINS  = 400;
	localparam int HOLD_CYC   = 300;

	// One blurred bin as seen on the output channel
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [BIN_W-1:0] bin;
		logic             done;
		logic             ovl;
	} blurred_bin_t;

	// Predicts blurred bins from accepted input bins and checks them in order
	class bin_blur_scoreboard;
		logic [MAG_W-1:0] window [WIN_SLOTS];
		logic [WIN_SLOTS-1:0] window_live;
		int unsigned next_bin;
		int unsigned bins_in;
		int unsigned frame_radius;
		bit long_frame;
		logic [RADIUS_W-1:0] radius_reg;
		blurred_bin_t blurred_q[$];
		int failures;

		function new();
			window_live  = '0;
			next_bin     = 0;
			bins_in      = 0;
			frame_radius = 0;
			long_frame   = 1'b0;
			radius_reg   = '0;
			failures     = 0;
		endfunction

		function void set_radius(logic [RADIUS_W-1:0] r);
			radius_reg = r;
		endfunction

		function int pending();
			return blurred_q.size();
		endfunction

		// Truncated mean of the live neighbors of slot s; edges pass unchanged
		function logic [MAG_W-1:0] mean_at(int s, int r, bit last);
			logic [MAG_W+4:0] sum;
			int cnt;
			int lo;
			int hi;
			int j;
			sum = '0;
			cnt = 0;
			if (!window_live[s+1] || last || r == 0)
				return window[s];
			lo = (s >= r) ? s - r : 0;
			hi = (s + r > WIN_SLOTS - 1) ? WIN_SLOTS - 1 : s + r;
			for (j = lo; j <= hi; j++) begin
				if (window_live[j]) begin
					sum += window[j];
					cnt++;
				end
			end
			if (cnt == 0)
				return window[s];
			return MAG_W'(sum / cnt);
		endfunction

		function void push_bin(int s, bit last);
			blurred_bin_t b;
			b.mag  = mean_at(s, frame_radius, last);
			b.bin  = BIN_W'(next_bin);
			b.done = last;
			b.ovl  = long_frame;
			blurred_q.push_back(b);
			if (next_bin < MAX_BINS_P - 1)
				next_bin++;
		endfunction

		// Accepted input bin: shift the window and predict what it releases
		function void take_bin(logic [MAG_W-1:0] mag, logic fe);
			int s;
			if (window_live == '0) begin
				frame_radius = (radius_reg > MAX_RAD_P) ? MAX_RAD_P : radius_reg;
				next_bin     = 0;
				bins_in      = 0;
				long_frame   = 1'b0;
			end
			if (bins_in >= MAX_BINS_P)
				long_frame = 1'b1;
			else
				bins_in++;
			for (s = WIN_SLOTS - 1; s > 0; s--)
				window[s] = window[s-1];
			window[0]   = mag;
			window_live = {window_live[WIN_SLOTS-2:0], 1'b1};
			if (!fe) begin
				if (window_live[frame_radius])
					push_bin(frame_radius, 1'b0);
			end else begin
				for (s = frame_radius; s >= 0; s--) begin
					if (window_live[s])
						push_bin(s, s == 0);
				end
				window_live = '0;
				next_bin    = 0;
				bins_in     = 0;
				long_frame  = 1'b0;
			end
		endfunction

		// Output transaction against the oldest prediction
		function void check_blurred(blurred_bin_t got);
			blurred_bin_t want;
			if (blurred_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected blurred bin: mag %h bin %0d done %b ovl %b",
						got.mag, got.bin, got.done, got.ovl);
				return;
			end
			want = blurred_q.pop_front();
			if (got.mag !== want.mag || got.bin !== want.bin || got.done !== want.done ||
				got.ovl !== want.ovl) begin
				failures++;
				if (failures <= 10)
					$display({"blurred bin mismatch: expected mag %h bin %0d done %b ovl %b,",
						" got mag %h bin %0d done %b ovl %b"},
						want.mag, want.bin, want.done, want.ovl,
						got.mag, got.bin, got.done, got.ovl);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sbb_in_if #(.MAG_BITS(MAG_W))  bin_in_ch ();
	sbb_out_if #(.MAG_BITS(MAG_W)) bin_out_ch ();
	sbb_cfg_if                     cfg_ch ();

	bin_blur_scoreboard sb;
	bit idle_on;
	int hold_cycles;
	int bins_sent;

	spectrum_box_blur_top #(
		.MAX_BINS  (MAX_BINS_P),
		.MAX_RADIUS(MAX_RAD_P),
		.MAG_BITS  (MAG_W)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bin_in (bin_in_ch.sink),
		.bin_out(bin_out_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// 10 time unit clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && bin_out_ch.valid && bin_out_ch.ready)
			sb.check_blurred('{mag: bin_out_ch.mag_out, bin: bin_out_ch.bin_number,
				done: bin_out_ch.frame_done, ovl: bin_out_ch.overlong});
	end

	// Output ready: random stall bursts, plus the long hold-off on request
	initial begin : out_sink
		int stretch;
		bin_out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				bin_out_ch.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (idle_on && $urandom_range(0, 1) == 1) begin
				bin_out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			bin_out_ch.ready <= 1'b1;
			stretch = $urandom_range(1, 40);
			repeat (stretch) begin
				@(posedge clk);
				if (hold_cycles > 0)
					break;
			end
		end
	end

	// Run limit
	initial begin
		#15_000_000;
		$display("spectrum_box_blur_top test failed");
		$finish;
	end

	function automatic logic [MAG_W-1:0] rand_mag();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return MAG_W'($urandom());
		endcase
	endfunction

	// One input transaction; valid stays high for a following bin
	task automatic send_bin(input logic [MAG_W-1:0] mag, input logic fe);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			bin_in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		bin_in_ch.valid     <= 1'b1;
		bin_in_ch.mag_in    <= mag;
		bin_in_ch.frame_end <= fe;
		do
			@(posedge clk);
		while (!bin_in_ch.ready);
		sb.take_bin(mag, fe);
		bins_sent++;
	endtask

	task automatic send_frame(input int len, input bit closed);
		int i;
		for (i = 0; i < len; i++)
			send_bin(rand_mag(), closed && i == len - 1);
	endtask

	// Stop offering bins and wait for every predicted bin to come out
	task automatic drain();
		bin_in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() > 0);
	endtask

	// Radius write while the block is idle
	task automatic set_radius_idle(input logic [RADIUS_W-1:0] r);
		drain();
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.blur_radius <= r;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sb.set_radius(r);
	endtask

	// Main sequence
	initial begin : stim
		int phase;
		int nframes;
		int f;
		int len;
		int goal;
		bit open_end;
		logic [RADIUS_W-1:0] r;

		sb          = new();
		idle_on     = 1'b0;
		hold_cycles = 0;
		bins_sent   = 0;
		arst_n              <= 1'b0;
		bin_in_ch.valid     <= 1'b0;
		bin_in_ch.mag_in    <= '0;
		bin_in_ch.frame_end <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.blur_radius  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pass through with extreme magnitudes
		set_radius_idle(3'd0);
		send_bin('0, 1'b0);
		send_bin('1, 1'b0);
		send_bin(24'h000001, 1'b1);

		// Largest radius on one- and two-bin frames: edges only
		set_radius_idle(3'd6);
		send_bin('1, 1'b1);
		send_bin('1, 1'b0);
		send_bin(24'h800000, 1'b1);

		// Radius above the maximum saturates
		set_radius_idle(3'd7);
		for (f = 0; f < 10; f++)
			send_bin((f % 2) ? '1 : '0, f == 9);

		// Radius rewritten mid-frame takes effect with the next frame
		set_radius_idle(3'd2);
		send_frame(4, 1'b0);
		set_radius_idle(3'd5);
		send_frame(3, 1'b1);
		send_frame(8, 1'b1);

		// Random frames under random radii and stalls
		idle_on = 1'b1;
		goal    = bins_sent + RAND_BINS;
		phase   = 0;
		while (bins_sent < goal) begin
			case (phase)
				0: r = 3'd0;
				1: r = 3'd7;
				2: r = 3'd6;
				3: r = 3'd1;
				default: r = RADIUS_W'($urandom_range(0, 7));
			endcase
			set_radius_idle(r);
			nframes = $urandom_range(1, 4);
			if (phase == 2) begin
				hold_cycles = HOLD_CYC;
				nframes = 4;
			end
			for (f = 0; f < nframes; f++) begin
				case ($urandom_range(0, 19))
					0: len = $urandom_range(41, 70);
					1, 2, 3: len = $urandom_range(17, 40);
					default: len = $urandom_range(1, 16);
				endcase
				if (phase == 2)
					len = 30;
				open_end = (f == nframes - 1) && $urandom_range(0, 4) == 0;
				send_frame(len, !open_end);
				if (f < nframes - 1 && $urandom_range(0, 9) == 0)
					drain();
			end
			phase++;
		end

		// Closing frames with no stalls
		idle_on = 1'b0;
		set_radius_idle(3'd1);
		send_frame(30, 1'b1);
		send_frame(3, 1'b1);

		drain();
		repeat (SETTLE_CYC) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("spectrum_box_blur_top test passed");
		else
			$display("spectrum_box_blur_top test failed");
		$finish;
	end

endmodule
